// File: src/bba_pkg.sv
// Shared constants, types and search functions for the bitmap block allocator.
package bba_pkg;

    localparam int BITMAP_BYTES = 32768;

    localparam int BYTE_W     = 8;
    localparam int WORD_BYTES = 8;
    localparam int WORD_W     = WORD_BYTES * BYTE_W;
    localparam int SUM_BITS   = 64;

    localparam int DATA_DEPTH = (BITMAP_BYTES + WORD_BYTES - 1) / WORD_BYTES;
    localparam int SUM_DEPTH  = (DATA_DEPTH + SUM_BITS - 1) / SUM_BITS;
    localparam int DATA_AW    = (DATA_DEPTH > 1) ? $clog2(DATA_DEPTH) : 1;
    localparam int SUM_AW     = (SUM_DEPTH > 1) ? $clog2(SUM_DEPTH) : 1;

    localparam int SBIT_W  = 6;
    localparam int BSEL_W  = 3;
    localparam int WIDX_W  = SUM_AW + SBIT_W;

    localparam int KIND_W  = 2;
    localparam int INDEX_W = 15;
    localparam int BLOCK_W = 18;

    localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd2;

    localparam logic [BYTE_W-1:0] FULL_BYTE = 8'hFF;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SUM_WAIT,
        ST_WORD_WAIT
    } state_t;

    typedef struct packed {
        logic              found;
        logic [SBIT_W-1:0] idx;
    } zero_pos_t;

    function automatic logic [2:0] low_zero8(input logic [7:0] v);
        logic [2:0] r;
        r = 3'd0;
        for (int i = 7; i >= 0; i--) begin
            if (!v[i]) begin
                r = 3'(i);
            end
        end
        return r;
    endfunction

    function automatic zero_pos_t first_zero64(input logic [WORD_W-1:0] v);
        zero_pos_t  r;
        logic [7:0] grp_free;
        logic [2:0] g;
        for (int k = 0; k < 8; k++) begin
            grp_free[k] = (v[8*k +: 8] != FULL_BYTE);
        end
        g       = low_zero8(~grp_free);
        r.found = |grp_free;
        r.idx   = {g, low_zero8(v[8*g +: 8])};
        return r;
    endfunction

    function automatic logic [WORD_W-1:0] bit_reverse_bytes(input logic [WORD_W-1:0] v);
        logic [WORD_W-1:0] r;
        for (int k = 0; k < WORD_BYTES; k++) begin
            for (int i = 0; i < BYTE_W; i++) begin
                r[8*k + i] = v[8*k + 7 - i];
            end
        end
        return r;
    endfunction

endpackage

// File: src/bba_ram.sv
// Generic simple dual-port RAM with registered read.
module bba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                                         clk,
    input  logic                                         wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                             wr_data,
    input  logic                                         rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                             rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: src/bitmap_block_allocator_core.sv
// Top level of the first-fit bitmap block allocator with two-level full summary.
//
//  channel   | handshake          | fields
//  ----------+--------------------+---------------------------------------
//  request   | start / busy       | kind, byte_index, byte_value
//  result    | done (one cycle)   | block_number, no_free, read_value
//
//  Load and read go through a bitmap word RAM read (a load then writes back);
//  allocate goes through summary RAM read, bitmap word RAM read, write back.
//  Kind 3, out-of-store loads and reads, and a full-map allocate finish in idle.
//  After reset a clearing pass over all DATA_DEPTH (4096) bitmap words holds busy high.
//  Results are strobed for one cycle; the receiver cannot stall them.
module bitmap_block_allocator_core
    import bba_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [KIND_W-1:0]  kind,
    input  logic [INDEX_W-1:0] byte_index,
    input  logic [BYTE_W-1:0]  byte_value,
    output logic               done,
    output logic [BLOCK_W-1:0] block_number,
    output logic               no_free,
    output logic [BYTE_W-1:0]  read_value
);

    state_t state_reg, state_next;

    logic [DATA_AW-1:0]   clr_cnt_reg, clr_cnt_next;
    logic [SUM_DEPTH-1:0] top_full_reg, top_full_next;
    logic                 done_reg, done_next;
    logic [KIND_W-1:0]    kind_reg, kind_next;
    logic [BSEL_W-1:0]    bsel_reg, bsel_next;
    logic [WIDX_W-1:0]    word_reg, word_next;
    logic [BYTE_W-1:0]    value_reg, value_next;
    logic [BLOCK_W-1:0]   block_number_reg, block_number_next;
    logic                 no_free_reg, no_free_next;
    logic [BYTE_W-1:0]    read_value_reg, read_value_next;

    logic                 data_we, data_re;
    logic [DATA_AW-1:0]   data_wa, data_ra;
    logic [WORD_W-1:0]    data_wd, data_rdata;
    logic                 sum_we, sum_re;
    logic [SUM_AW-1:0]    sum_wa, sum_ra;
    logic [SUM_BITS-1:0]  sum_wd, sum_rdata;

    logic                 in_range;
    logic [WIDX_W-1:0]    in_word;
    logic                 top_found;
    logic [SUM_AW-1:0]    top_idx;
    logic                 clr_last;
    logic [SUM_AW-1:0]    clr_sum_idx;
    logic [WORD_W-1:0]    clr_word;
    logic [SUM_BITS-1:0]  clr_sum;
    zero_pos_t            sum_pos;
    zero_pos_t            data_pos;
    logic [WORD_W-1:0]    new_word;
    logic [SUM_BITS-1:0]  new_sum;
    logic [SUM_AW-1:0]    cur_sum_idx;

    bba_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DATA_DEPTH)
    ) u_data_ram (
        .clk     (clk),
        .wr_en   (data_we),
        .wr_addr (data_wa),
        .wr_data (data_wd),
        .rd_en   (data_re),
        .rd_addr (data_ra),
        .rd_data (data_rdata)
    );

    bba_ram #(
        .WIDTH (SUM_BITS),
        .DEPTH (SUM_DEPTH)
    ) u_sum_ram (
        .clk     (clk),
        .wr_en   (sum_we),
        .wr_addr (sum_wa),
        .wr_data (sum_wd),
        .rd_en   (sum_re),
        .rd_addr (sum_ra),
        .rd_data (sum_rdata)
    );

    assign busy         = (state_reg != ST_IDLE);
    assign done         = done_reg;
    assign block_number = block_number_reg;
    assign no_free      = no_free_reg;
    assign read_value   = read_value_reg;

    assign in_range    = (32'(byte_index) < BITMAP_BYTES);
    assign in_word     = WIDX_W'(byte_index >> BSEL_W);
    assign clr_last    = (32'(clr_cnt_reg) == DATA_DEPTH - 1);
    assign clr_sum_idx = SUM_AW'(clr_cnt_reg);
    assign cur_sum_idx = word_reg[WIDX_W-1 -: SUM_AW];
    assign top_found   = ~&top_full_reg;
    assign sum_pos     = first_zero64(sum_rdata);
    assign data_pos    = first_zero64(bit_reverse_bytes(data_rdata));

    always_comb
    begin
        top_idx = '0;
        for (int i = SUM_DEPTH - 1; i >= 0; i--)
        begin
            if (!top_full_reg[i])
            begin
                top_idx = SUM_AW'(i);
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < WORD_BYTES; k++)
        begin
            clr_word[8*k +: 8] = (int'(clr_cnt_reg) * WORD_BYTES + k >= BITMAP_BYTES)
                                 ? FULL_BYTE : '0;
        end
        for (int b = 0; b < SUM_BITS; b++)
        begin
            clr_sum[b] = (int'(clr_sum_idx) * SUM_BITS + b >= DATA_DEPTH);
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    if ((kind == KIND_LOAD || kind == KIND_READ) && in_range)
                    begin
                        state_next = ST_WORD_WAIT;
                    end
                    else if (kind == KIND_ALLOC && top_found)
                    begin
                        state_next = ST_SUM_WAIT;
                    end
                end
            end
            ST_SUM_WAIT:
            begin
                state_next = ST_WORD_WAIT;
            end
            ST_WORD_WAIT:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and memory controls
    always_comb
    begin
        clr_cnt_next      = clr_cnt_reg;
        top_full_next     = top_full_reg;
        done_next         = 1'b0;
        kind_next         = kind_reg;
        bsel_next         = bsel_reg;
        word_next         = word_reg;
        value_next        = value_reg;
        block_number_next = block_number_reg;
        no_free_next      = no_free_reg;
        read_value_next   = read_value_reg;

        data_we  = 1'b0;
        data_wa  = DATA_AW'(word_reg);
        data_wd  = '0;
        data_re  = 1'b0;
        data_ra  = DATA_AW'(in_word);
        sum_we   = 1'b0;
        sum_wa   = cur_sum_idx;
        sum_wd   = '0;
        sum_re   = 1'b0;
        sum_ra   = SUM_AW'(in_word >> SBIT_W);
        new_word = data_rdata;
        new_sum  = sum_rdata;

        case (state_reg)
            ST_CLEAR:
            begin
                data_we      = 1'b1;
                data_wa      = clr_cnt_reg;
                data_wd      = clr_word;
                sum_we       = (32'(clr_cnt_reg) < SUM_DEPTH);
                sum_wa       = clr_sum_idx;
                sum_wd       = clr_sum;
                clr_cnt_next = clr_cnt_reg + 1'b1;
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    kind_next  = kind;
                    bsel_next  = byte_index[BSEL_W-1:0];
                    value_next = byte_value;
                    word_next  = in_word;
                    if ((kind == KIND_LOAD || kind == KIND_READ) && in_range)
                    begin
                        data_re = 1'b1;
                        sum_re  = 1'b1;
                    end
                    else if (kind == KIND_ALLOC && top_found)
                    begin
                        sum_re    = 1'b1;
                        sum_ra    = top_idx;
                        word_next = {top_idx, {SBIT_W{1'b0}}};
                    end
                    else
                    begin
                        done_next         = 1'b1;
                        block_number_next = '0;
                        read_value_next   = '0;
                        no_free_next      = (kind == KIND_ALLOC);
                    end
                end
            end
            ST_SUM_WAIT:
            begin
                word_next = {cur_sum_idx, sum_pos.idx};
                data_re   = 1'b1;
                data_ra   = DATA_AW'({cur_sum_idx, sum_pos.idx});
            end
            ST_WORD_WAIT:
            begin
                done_next         = 1'b1;
                block_number_next = '0;
                no_free_next      = 1'b0;
                read_value_next   = '0;
                case (kind_reg)
                    KIND_READ:
                    begin
                        read_value_next = data_rdata[8*bsel_reg +: 8];
                    end
                    KIND_LOAD:
                    begin
                        new_word[8*bsel_reg +: 8] = value_reg;
                        new_sum[word_reg[SBIT_W-1:0]] = &new_word;
                        data_we = 1'b1;
                        data_wd = new_word;
                        sum_we  = 1'b1;
                        sum_wd  = new_sum;
                        top_full_next[cur_sum_idx] = &new_sum;
                    end
                    KIND_ALLOC:
                    begin
                        new_word[{data_pos.idx[5:3], 3'd7 - data_pos.idx[2:0]}] = 1'b1;
                        new_sum[word_reg[SBIT_W-1:0]] = &new_word;
                        data_we = 1'b1;
                        data_wd = new_word;
                        sum_we  = 1'b1;
                        sum_wd  = new_sum;
                        top_full_next[cur_sum_idx] = &new_sum;
                        block_number_next = BLOCK_W'({word_reg, data_pos.idx});
                    end
                    default:
                    begin
                        block_number_next = '0;
                    end
                endcase
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_cnt_reg  <= '0;
            top_full_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            top_full_reg <= top_full_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg         <= kind_next;
        bsel_reg         <= bsel_next;
        word_reg         <= word_next;
        value_reg        <= value_next;
        block_number_reg <= block_number_next;
        no_free_reg      <= no_free_next;
        read_value_reg   <= read_value_next;
    end

    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (done || busy))
        else $error("accepted item neither finished nor in progress");

    a_no_free_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (done && no_free) |-> (block_number == '0 && read_value == '0))
        else $error("no_free result carries nonzero fields");

    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE || state_reg == ST_SUM_WAIT) |-> (!data_we && !sum_we))
        else $error("memory write outside clear or write-back");

    a_alloc_word_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WORD_WAIT && kind_reg == KIND_ALLOC) |-> (data_rdata != '1))
        else $error("summary pointed allocate at a full bitmap word");

    a_sum_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SUM_WAIT) |-> sum_pos.found)
        else $error("top flags pointed at a full summary word");

endmodule

// File: dv/bitmap_alloc_checker.sv
// Checker for the bitmap block allocator: tracks the bitmap, predicts each result and compares.
module bitmap_alloc_checker
    import bba_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic [KIND_W-1:0]  kind,
    input  logic [INDEX_W-1:0] byte_index,
    input  logic [BYTE_W-1:0]  byte_value,
    input  logic               done,
    input  logic [BLOCK_W-1:0] block_number,
    input  logic               no_free,
    input  logic [BYTE_W-1:0]  read_value,
    output int                 fail_count,
    output int                 pending
);

    typedef struct {
        logic [BLOCK_W-1:0] block;
        logic               none;
        logic [BYTE_W-1:0]  rd;
        int                 seq;
    } alloc_result_t;

    logic [BYTE_W-1:0] bitmap_mirror [BITMAP_BYTES];
    int                lowest_open_byte;
    alloc_result_t     expected_results [$];
    int                items_seen;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        fail_count++;
    endtask

    function automatic alloc_result_t predict_outcome(
        input logic [KIND_W-1:0]  k,
        input logic [INDEX_W-1:0] idx,
        input logic [BYTE_W-1:0]  val
    );
        alloc_result_t     r;
        int                i;
        int                j;
        logic [BYTE_W-1:0] mask;
        r.block = '0;
        r.none  = 1'b0;
        r.rd    = '0;
        r.seq   = items_seen;
        case (k)
            KIND_LOAD:
            begin
                if (int'(idx) < BITMAP_BYTES)
                begin
                    bitmap_mirror[idx] = val;
                    if (val != FULL_BYTE && int'(idx) < lowest_open_byte)
                    begin
                        lowest_open_byte = int'(idx);
                    end
                end
            end
            KIND_READ:
            begin
                if (int'(idx) < BITMAP_BYTES)
                begin
                    r.rd = bitmap_mirror[idx];
                end
            end
            KIND_ALLOC:
            begin
                i = lowest_open_byte;
                while (i < BITMAP_BYTES && bitmap_mirror[i] == FULL_BYTE)
                begin
                    i++;
                end
                lowest_open_byte = i;
                if (i == BITMAP_BYTES)
                begin
                    r.none = 1'b1;
                end
                else
                begin
                    j    = 0;
                    mask = 8'h80;
                    while ((bitmap_mirror[i] & mask) != '0)
                    begin
                        j++;
                        mask = mask >> 1;
                    end
                    bitmap_mirror[i] = bitmap_mirror[i] | mask;
                    r.block = BLOCK_W'(i * 8 + j);
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        alloc_result_t want;
        if (!rst_n)
        begin
            foreach (bitmap_mirror[i])
            begin
                bitmap_mirror[i] = '0;
            end
            lowest_open_byte = 0;
            items_seen = 0;
            fail_count = 0;
            expected_results.delete();
            pending <= 0;
        end
        else
        begin
            if (done)
            begin
                if (expected_results.size() == 0)
                begin
                    report_mismatch($sformatf("result with no item pending: block %0h",
                                              block_number));
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (block_number !== want.block)
                    begin
                        report_mismatch($sformatf("item %0d block_number got %0h want %0h",
                                                  want.seq, block_number, want.block));
                    end
                    if (no_free !== want.none)
                    begin
                        report_mismatch($sformatf("item %0d no_free got %0b want %0b",
                                                  want.seq, no_free, want.none));
                    end
                    if (read_value !== want.rd)
                    begin
                        report_mismatch($sformatf("item %0d read_value got %0h want %0h",
                                                  want.seq, read_value, want.rd));
                    end
                end
            end
            if (start && !busy)
            begin
                expected_results.push_back(predict_outcome(kind, byte_index, byte_value));
                items_seen++;
            end
            pending <= expected_results.size();
        end
    end

endmodule

// File: dv/testbench.sv
// Top of the bitmap block allocator testbench: clock, reset, stimulus and verdict.
module testbench;
    import bba_pkg::*;

    localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 10;

    logic               clk        = 1'b0;
    logic               rst_n      = 1'b0;
    logic               start      = 1'b0;
    logic [KIND_W-1:0]  kind       = KIND_LOAD;
    logic [INDEX_W-1:0] byte_index = '0;
    logic [BYTE_W-1:0]  byte_value = '0;
    logic               busy;
    logic               done;
    logic [BLOCK_W-1:0] block_number;
    logic               no_free;
    logic [BYTE_W-1:0]  read_value;

    int fail_count;
    int pending;
    int quiet_cycles = 0;
    int idle_pct     = 13;

    always #5 clk = ~clk;

    bitmap_block_allocator_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .kind         (kind),
        .byte_index   (byte_index),
        .byte_value   (byte_value),
        .done         (done),
        .block_number (block_number),
        .no_free      (no_free),
        .read_value   (read_value)
    );

    bitmap_alloc_checker alloc_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .kind         (kind),
        .byte_index   (byte_index),
        .byte_value   (byte_value),
        .done         (done),
        .block_number (block_number),
        .no_free      (no_free),
        .read_value   (read_value),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    always @(posedge clk)
    begin
        if ((start && !busy) || done)
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic issue(
        input logic [KIND_W-1:0]  k,
        input logic [INDEX_W-1:0] idx,
        input logic [BYTE_W-1:0]  val
    );
        start      <= 1'b1;
        kind       <= k;
        byte_index <= idx;
        byte_value <= val;
        do
        begin
            @(posedge clk);
        end
        while (busy);
        if ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    task automatic random_item();
        int                 pick;
        logic [INDEX_W-1:0] idx;
        logic [BYTE_W-1:0]  val;
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 4) == 0)
        begin
            idx = INDEX_W'($urandom);
        end
        else
        begin
            idx = INDEX_W'($urandom_range(0, 63));
        end
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: val = FULL_BYTE;
            5:             val = '0;
            default:       val = BYTE_W'($urandom);
        endcase
        if (pick < 40)
        begin
            issue(KIND_ALLOC, idx, val);
        end
        else if (pick < 58)
        begin
            issue(KIND_READ, idx, val);
        end
        else if (pick < 95)
        begin
            issue(KIND_LOAD, idx, val);
        end
        else
        begin
            issue(KIND_SPARE, INDEX_W'($urandom), BYTE_W'($urandom));
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        issue(KIND_READ, '0, '0);
        issue(KIND_ALLOC, '0, '0);
        issue(KIND_ALLOC, '1, '1);
        issue(KIND_READ, '0, '0);
        issue(KIND_LOAD, '0, FULL_BYTE);
        issue(KIND_LOAD, INDEX_W'(1), 8'h7F);
        issue(KIND_ALLOC, '0, '0);
        issue(KIND_LOAD, INDEX_W'(1), 8'hFE);
        issue(KIND_ALLOC, '0, '0);
        issue(KIND_READ, INDEX_W'(1), '0);
        issue(KIND_LOAD, '1, 8'hA5);
        issue(KIND_READ, '1, '0);
        issue(KIND_LOAD, INDEX_W'(15'h5555), 8'h00);
        issue(KIND_READ, INDEX_W'(15'h5555), '1);
        issue(KIND_LOAD, INDEX_W'(15'h2AAA), 8'h5A);
        issue(KIND_READ, INDEX_W'(15'h2AAA), '0);
        issue(KIND_SPARE, '1, '1);
        issue(KIND_SPARE, '0, '0);
        issue(KIND_LOAD, '0, '0);
        issue(KIND_ALLOC, '0, '0);
        issue(KIND_READ, '0, '0);

        repeat (410) random_item();
        idle_pct = 66;
        repeat (410) random_item();
        idle_pct = 0;
        repeat (410) random_item();

        issue(KIND_LOAD, '1, 8'hFE);
        issue(KIND_ALLOC, '0, '0);
        issue(KIND_ALLOC, '0, '0);
        issue(KIND_READ, '1, '0);
        start <= 1'b0;

        do
        begin
            @(posedge clk);
        end
        while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// File: sim.f
src/bba_pkg.sv
src/bba_ram.sv
src/bitmap_block_allocator_core.sv
dv/bitmap_alloc_checker.sv
dv/testbench.sv
